@@ sv/box_stack_max_height_defines.svh @@
// Assertion macros shared by the box stacking logic.
// Each macro expects signals named clk and rst in the scope where it is used.
`ifndef BOX_STACK_MAX_HEIGHT_DEFINES_SVH
`define BOX_STACK_MAX_HEIGHT_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define BSMH_ASSERT_NOW(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define BSMH_ASSERT_NEXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/bsmh_pkg.sv @@
`timescale 1ns / 1ps

package bsmh_pkg;

  // Width of each dimension field on the input port.
  localparam int IN_DIM_BITS = 16;

  // Width of the reported stack height and its saturation value.
  localparam int HEIGHT_BITS = 22;
  localparam logic [HEIGHT_BITS-1:0] HEIGHT_MAX = '1;

  // One box as it arrives.
  typedef struct packed {
    logic [IN_DIM_BITS-1:0] box_height;
    logic [IN_DIM_BITS-1:0] box_width;
    logic [IN_DIM_BITS-1:0] box_length;
    logic                   last_box;
  } box_in_t;

  // Result of one search.
  typedef struct packed {
    logic [HEIGHT_BITS-1:0] max_height;
    logic                   boxes_dropped;
  } box_out_t;

endpackage

@@ sv/box_stack_max_height.sv @@
`timescale 1ns / 1ps
// Channel | Direction | Handshake          | Payload
// --------+-----------+--------------------+------------------------------------
// in      | input     | in_valid/in_ready  | in_data  (box dimensions, last flag)
// out     | output    | out_valid/out_ready| out_data (max_height, boxes_dropped)
//
// A box that fits in the store is accepted, then its three orientations are written in S_LOAD
// through the single store write port; a dropped box is only accepted.
// On the last box a search runs over n = 3 * boxes oriented entries: one selection scan
// plus one scan per entry, each scan reading every entry through the shared compare unit
// and followed by a step.
// Synchronous active-high reset clears the sequencer, box count and drop flag; the
// store and tower memories hold no reset value and are only read where written.
// in_ready is low during loading and search; a pending result stalls only the final step.

module box_stack_max_height #(
  parameter int MAX_BOXES = 16,
  parameter int DIM_BITS  = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bsmh_pkg::box_in_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bsmh_pkg::box_out_t out_data
);

  import bsmh_pkg::*;

  `include "box_stack_max_height_defines.svh"

  localparam int SLOTS   = 3 * MAX_BOXES;
  localparam int SLOT_W  = $clog2(SLOTS);
  localparam int NUM_W   = $clog2(SLOTS + 1);
  localparam int CNT_W   = $clog2(MAX_BOXES + 1);
  localparam int SUM_W   = ((HEIGHT_BITS > DIM_BITS) ? HEIGHT_BITS : DIM_BITS) + 1;

  typedef struct packed {
    logic [DIM_BITS-1:0] height;
    logic [DIM_BITS-1:0] wide;
    logic [DIM_BITS-1:0] narrow;
  } obox_t;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001,
    S_LOAD = 6'b000010,
    S_INIT = 6'b000100,
    S_SCAN = 6'b001000,
    S_STEP = 6'b010000,
    S_FIN  = 6'b100000
  } state_t;

  state_t state;

  // Box set bookkeeping.
  logic [CNT_W-1:0]       box_count;
  logic                   overflow_flag;
  logic [DIM_BITS-1:0]    dim_h;
  logic [DIM_BITS-1:0]    dim_w;
  logic [DIM_BITS-1:0]    dim_l;
  logic                   last_pend;
  logic [1:0]             ori;

  // Search state.
  logic [NUM_W-1:0]       n_slots;
  logic [NUM_W-1:0]       scan_addr;
  logic                   rd_vld;
  logic [SLOT_W-1:0]      rd_idx;
  obox_t                  rd_entry;
  logic [HEIGHT_BITS-1:0] rd_best;
  logic                   has_top;
  logic [SLOT_W-1:0]      top_idx;
  obox_t                  top_box;
  logic [HEIGHT_BITS-1:0] below;
  logic                   cand_vld;
  logic [SLOT_W-1:0]      cand_idx;
  obox_t                  cand_box;
  logic [SLOTS-1:0]       done;
  logic [HEIGHT_BITS-1:0] best_all;

  // Memories for oriented boxes and the tallest tower with each entry on top.
  obox_t                  store_mem [SLOTS];
  logic [HEIGHT_BITS-1:0] best_mem  [SLOTS];

  // Input dimensions cut or zero-extended to DIM_BITS.
  logic [IN_DIM_BITS+DIM_BITS-1:0] ext_h;
  logic [IN_DIM_BITS+DIM_BITS-1:0] ext_w;
  logic [IN_DIM_BITS+DIM_BITS-1:0] ext_l;
  assign ext_h = {{DIM_BITS{1'b0}}, in_data.box_height};
  assign ext_w = {{DIM_BITS{1'b0}}, in_data.box_width};
  assign ext_l = {{DIM_BITS{1'b0}}, in_data.box_length};

  logic in_fire;
  logic full;
  assign in_ready = (state == S_IDLE);
  assign in_fire  = in_valid && in_ready;
  assign full     = (box_count >= CNT_W'(MAX_BOXES));

  // Orientation written in this load cycle: one dimension up, the rest sorted as base.
  logic [DIM_BITS-1:0] ld_up;
  logic [DIM_BITS-1:0] ld_a;
  logic [DIM_BITS-1:0] ld_b;
  obox_t               ld_box;
  logic [SLOT_W-1:0]   ld_slot;

  always_comb begin
    case (ori)
      2'd1: begin
        ld_up = dim_w;
        ld_a  = dim_h;
        ld_b  = dim_l;
      end
      2'd2: begin
        ld_up = dim_l;
        ld_a  = dim_w;
        ld_b  = dim_h;
      end
      default: begin
        ld_up = dim_h;
        ld_a  = dim_w;
        ld_b  = dim_l;
      end
    endcase
    ld_box.height = ld_up;
    ld_box.wide   = (ld_a > ld_b) ? ld_a : ld_b;
    ld_box.narrow = (ld_a > ld_b) ? ld_b : ld_a;
  end

  assign ld_slot = SLOT_W'(({{SLOT_W{1'b0}}, box_count} * 3) + ori);

  // Scan read port and the shared compare unit on the registered read data.
  logic rd_issue;
  logic carries;
  logic pick;
  assign rd_issue = (state == S_SCAN) && (scan_addr < n_slots);
  assign carries  = rd_vld && has_top && (rd_entry.wide > top_box.wide) &&
                    (rd_entry.narrow > top_box.narrow) && (rd_best > below);
  assign pick     = rd_vld && !done[rd_idx] &&
                    (!cand_vld || (rd_entry.wide > cand_box.wide));

  // Tower height with the current top box, saturated to the result width.
  logic [SUM_W-1:0]       top_sum;
  logic [HEIGHT_BITS-1:0] top_total;
  assign top_sum   = SUM_W'(below) + SUM_W'(top_box.height);
  assign top_total = (top_sum > SUM_W'(HEIGHT_MAX)) ? HEIGHT_MAX : top_sum[HEIGHT_BITS-1:0];

  logic fin_go;
  assign fin_go = (state == S_FIN) && (!out_valid || out_ready);

  // Memory ports.
  always_ff @(posedge clk) begin
    if (state == S_LOAD) begin
      store_mem[ld_slot] <= ld_box;
    end
    if ((state == S_STEP) && has_top) begin
      best_mem[top_idx] <= top_total;
    end
    if (rd_issue) begin
      rd_entry <= store_mem[scan_addr[SLOT_W-1:0]];
      rd_best  <= best_mem[scan_addr[SLOT_W-1:0]];
      rd_idx   <= scan_addr[SLOT_W-1:0];
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      box_count     <= '0;
      overflow_flag <= 1'b0;
      ori           <= '0;
      rd_vld        <= 1'b0;
      has_top       <= 1'b0;
      cand_vld      <= 1'b0;
      done          <= '0;
      out_valid     <= 1'b0;
    end else begin
      rd_vld <= rd_issue;
      if (out_valid && out_ready && !fin_go) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (in_fire) begin
            dim_h     <= ext_h[DIM_BITS-1:0];
            dim_w     <= ext_w[DIM_BITS-1:0];
            dim_l     <= ext_l[DIM_BITS-1:0];
            last_pend <= in_data.last_box;
            ori       <= '0;
            if (!full) begin
              state <= S_LOAD;
            end else begin
              overflow_flag <= 1'b1;
              if (in_data.last_box) begin
                state <= S_INIT;
              end
            end
          end
        end
        S_LOAD: begin
          ori <= ori + 2'd1;
          if (ori == 2'd2) begin
            box_count <= box_count + CNT_W'(1);
            state     <= last_pend ? S_INIT : S_IDLE;
          end
        end
        S_INIT: begin
          n_slots   <= NUM_W'({{NUM_W{1'b0}}, box_count} * 3);
          scan_addr <= '0;
          done      <= '0;
          has_top   <= 1'b0;
          cand_vld  <= 1'b0;
          below     <= '0;
          best_all  <= '0;
          state     <= S_SCAN;
        end
        S_SCAN: begin
          if (rd_issue) begin
            scan_addr <= scan_addr + NUM_W'(1);
          end
          if (carries) begin
            below <= rd_best;
          end
          if (pick) begin
            cand_vld <= 1'b1;
            cand_idx <= rd_idx;
            cand_box <= rd_entry;
          end
          if ((scan_addr == n_slots) && !rd_vld) begin
            state <= S_STEP;
          end
        end
        S_STEP: begin
          if (has_top && (top_total > best_all)) begin
            best_all <= top_total;
          end
          if (cand_vld) begin
            has_top           <= 1'b1;
            top_idx           <= cand_idx;
            top_box           <= cand_box;
            done[cand_idx]    <= 1'b1;
            cand_vld          <= 1'b0;
            below             <= '0;
            scan_addr         <= '0;
            state             <= S_SCAN;
          end else begin
            state <= S_FIN;
          end
        end
        S_FIN: begin
          if (fin_go) begin
            out_data.max_height    <= best_all;
            out_data.boxes_dropped <= overflow_flag;
            out_valid              <= 1'b1;
            box_count              <= '0;
            overflow_flag          <= 1'b0;
            state                  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  // Checks on the sequencer.
  `BSMH_ASSERT_NOW(a_count_bound, 1'b1, box_count <= CNT_W'(MAX_BOXES), "box count past capacity")
  `BSMH_ASSERT_NEXT(a_set_cleared, fin_go, (box_count == '0) && !overflow_flag && out_valid, "set not cleared after result")
  `BSMH_ASSERT_NOW(a_top_marked, (state == S_SCAN) && has_top, done[top_idx], "scan top not marked done")
  `BSMH_ASSERT_NEXT(a_store_on_room, in_fire && !full, state == S_LOAD, "box with room not stored")

endmodule
